/* src/cmpq_pkg.sv */
// ----------------------------------------------------------------------------
// cmpq_pkg
// shared constants, codes and item types of the complex magnitude priority queue
// ----------------------------------------------------------------------------
package cmpq_pkg;

    localparam int CAPACITY   = 64;
    localparam int PART_WIDTH = 16;

    // a square of a signed part fits in 2*PART_WIDTH-1 bits, their sum in 2*PART_WIDTH
    localparam int SQ_W    = 2 * PART_WIDTH - 1;
    localparam int KEY_W   = 2 * PART_WIDTH;
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // classified item as it travels from the front end to the sorted array
    typedef struct packed {
        logic                         cmd;
        logic signed [PART_WIDTH-1:0] re;
        logic signed [PART_WIDTH-1:0] im;
        logic [KEY_W-1:0]             key;
    } op_item_t;

endpackage

/* src/cmpq_front.sv */
// ----------------------------------------------------------------------------
// cmpq_front
// takes an item, squares both parts, then forms the key and pushes to the queue
// ----------------------------------------------------------------------------
module cmpq_front
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic                                    command,
    input  logic signed [cmpq_pkg::PART_WIDTH-1:0]  real_part,
    input  logic signed [cmpq_pkg::PART_WIDTH-1:0]  imag_part,
    input  logic                                    fifo_full,
    output logic                                    busy,
    output logic                                    push,
    output cmpq_pkg::op_item_t                      push_item
);

    logic                                   valid_reg;
    logic                                   valid_next;
    logic                                   cmd_reg;
    logic signed [cmpq_pkg::PART_WIDTH-1:0] re_reg;
    logic signed [cmpq_pkg::PART_WIDTH-1:0] im_reg;
    logic [cmpq_pkg::SQ_W-1:0]              sq_re_reg;
    logic [cmpq_pkg::SQ_W-1:0]              sq_im_reg;
    logic signed [cmpq_pkg::KEY_W-1:0]      prod_re;
    logic signed [cmpq_pkg::KEY_W-1:0]      prod_im;
    logic                                   accept;

    assign busy   = valid_reg && fifo_full;
    assign accept = start && !busy;
    assign push   = valid_reg && !fifo_full;

    // squares are never negative, so the top bit of the product is dropped
    assign prod_re = cmpq_pkg::KEY_W'(real_part) * cmpq_pkg::KEY_W'(real_part);
    assign prod_im = cmpq_pkg::KEY_W'(imag_part) * cmpq_pkg::KEY_W'(imag_part);

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            re_reg    <= real_part;
            im_reg    <= imag_part;
            sq_re_reg <= prod_re[cmpq_pkg::SQ_W-1:0];
            sq_im_reg <= prod_im[cmpq_pkg::SQ_W-1:0];
        end
    end

    always_comb
    begin
        push_item.cmd = cmd_reg;
        push_item.re  = re_reg;
        push_item.im  = im_reg;
        push_item.key = cmpq_pkg::KEY_W'(sq_re_reg) + cmpq_pkg::KEY_W'(sq_im_reg);
    end

endmodule

/* src/cmpq_fifo.sv */
// ----------------------------------------------------------------------------
// cmpq_fifo
// short item queue between the front end and the sorted array
// ----------------------------------------------------------------------------
module cmpq_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  cmpq_pkg::op_item_t push_item,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output cmpq_pkg::op_item_t head_item
);

    cmpq_pkg::op_item_t                 mem_reg [cmpq_pkg::FIFO_DEPTH];
    logic [cmpq_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [cmpq_pkg::FIFO_PTR_W-1:0]    wr_ptr_next;
    logic [cmpq_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [cmpq_pkg::FIFO_PTR_W-1:0]    rd_ptr_next;
    logic [cmpq_pkg::FIFO_CNT_W-1:0]    cnt_reg;
    logic [cmpq_pkg::FIFO_CNT_W-1:0]    cnt_next;
    logic                               do_push;
    logic                               do_pop;

    assign full      = (cnt_reg == cmpq_pkg::FIFO_CNT_W'(cmpq_pkg::FIFO_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == cmpq_pkg::FIFO_PTR_W'(cmpq_pkg::FIFO_DEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == cmpq_pkg::FIFO_PTR_W'(cmpq_pkg::FIFO_DEPTH - 1))
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* src/cmpq_back.sv */
// ----------------------------------------------------------------------------
// cmpq_back
// sorted row of cells: insert and pop move the cells in parallel, all in the same cycle
// ----------------------------------------------------------------------------
module cmpq_back
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    head_valid,
    input  cmpq_pkg::op_item_t                      head_item,
    output logic                                    head_pop,
    output logic                                    done,
    output logic [1:0]                              status,
    output logic signed [cmpq_pkg::PART_WIDTH-1:0]  out_real,
    output logic signed [cmpq_pkg::PART_WIDTH-1:0]  out_imag,
    output logic [cmpq_pkg::COUNT_W-1:0]            entry_count,
    output logic                                    now_empty
);

    logic signed [cmpq_pkg::PART_WIDTH-1:0] cell_re_reg  [cmpq_pkg::CAPACITY];
    logic signed [cmpq_pkg::PART_WIDTH-1:0] cell_im_reg  [cmpq_pkg::CAPACITY];
    logic [cmpq_pkg::KEY_W-1:0]             cell_key_reg [cmpq_pkg::CAPACITY];
    logic [cmpq_pkg::CAPACITY-1:0]          keep_ahead;

    logic [cmpq_pkg::COUNT_W-1:0]           count_reg;
    logic [cmpq_pkg::COUNT_W-1:0]           count_next;
    logic                                   do_insert;
    logic                                   do_pop;

    logic                                   done_reg;
    cmpq_pkg::status_t                      status_reg;
    cmpq_pkg::status_t                      status_next;
    logic signed [cmpq_pkg::PART_WIDTH-1:0] out_re_reg;
    logic signed [cmpq_pkg::PART_WIDTH-1:0] out_im_reg;
    logic signed [cmpq_pkg::PART_WIDTH-1:0] out_re_next;
    logic signed [cmpq_pkg::PART_WIDTH-1:0] out_im_next;
    logic                                   empty_reg;

    assign head_pop  = head_valid;
    assign do_insert = head_valid && (head_item.cmd == cmpq_pkg::CMD_INSERT)
                       && (count_reg != cmpq_pkg::COUNT_W'(cmpq_pkg::CAPACITY));
    assign do_pop    = head_valid && (head_item.cmd == cmpq_pkg::CMD_POP)
                       && (count_reg != '0);

    genvar g;
    generate
        for (g = 0; g < cmpq_pkg::CAPACITY; g++)
        begin : g_cell
            // valid cells with a key not below the new one stay in place
            assign keep_ahead[g] = (cmpq_pkg::COUNT_W'(g) < count_reg)
                                   && (cell_key_reg[g] >= head_item.key);

            always_ff @(posedge clk)
            begin
                if (do_insert && !keep_ahead[g])
                begin
                    if (g == 0)
                    begin
                        cell_re_reg[g]  <= head_item.re;
                        cell_im_reg[g]  <= head_item.im;
                        cell_key_reg[g] <= head_item.key;
                    end
                    else if (keep_ahead[(g == 0) ? 0 : g - 1])
                    begin
                        cell_re_reg[g]  <= head_item.re;
                        cell_im_reg[g]  <= head_item.im;
                        cell_key_reg[g] <= head_item.key;
                    end
                    else
                    begin
                        cell_re_reg[g]  <= cell_re_reg[(g == 0) ? 0 : g - 1];
                        cell_im_reg[g]  <= cell_im_reg[(g == 0) ? 0 : g - 1];
                        cell_key_reg[g] <= cell_key_reg[(g == 0) ? 0 : g - 1];
                    end
                end
                else if (do_pop && (g < cmpq_pkg::CAPACITY - 1))
                begin
                    cell_re_reg[g]  <= cell_re_reg[(g < cmpq_pkg::CAPACITY - 1) ? g + 1 : g];
                    cell_im_reg[g]  <= cell_im_reg[(g < cmpq_pkg::CAPACITY - 1) ? g + 1 : g];
                    cell_key_reg[g] <= cell_key_reg[(g < cmpq_pkg::CAPACITY - 1) ? g + 1 : g];
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        out_re_next = '0;
        out_im_next = '0;
        status_next = cmpq_pkg::ST_INSERTED;
        case (head_item.cmd)
            cmpq_pkg::CMD_INSERT:
            begin
                if (do_insert)
                begin
                    count_next  = count_reg + 1'b1;
                    status_next = cmpq_pkg::ST_INSERTED;
                end
                else
                begin
                    status_next = cmpq_pkg::ST_FULL;
                end
            end
            cmpq_pkg::CMD_POP:
            begin
                if (do_pop)
                begin
                    count_next  = count_reg - 1'b1;
                    out_re_next = cell_re_reg[0];
                    out_im_next = cell_im_reg[0];
                    status_next = cmpq_pkg::ST_POPPED;
                end
                else
                begin
                    status_next = cmpq_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                status_next = cmpq_pkg::ST_INSERTED;
            end
        endcase
        if (!head_valid)
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_valid)
        begin
            status_reg <= status_next;
            out_re_reg <= out_re_next;
            out_im_reg <= out_im_next;
            empty_reg  <= (count_next == '0);
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign out_real    = out_re_reg;
    assign out_imag    = out_im_reg;
    assign entry_count = count_reg;
    assign now_empty   = empty_reg;

endmodule

/* src/complex_magnitude_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// complex_magnitude_priority_queue_unit
// max-priority queue of complex numbers ordered by squared magnitude
// ----------------------------------------------------------------------------
// usage
//   an item is taken at a rising edge with start high and busy low; command
//   0 inserts real_part/imag_part, command 1 pops the entry with the largest
//   re*re+im*im (equal keys leave in arrival order)
//   every item gives exactly one result: done is high for one cycle with
//   status, out_real, out_imag, entry_count and now_empty valid alongside
//   an item is registered at the squares, then as a key in the queue, then in
//   the sorted array, whose result registers drive the result strobe
//   throughput: one item per cycle while busy stays low; the front end squares
//   while the sorted row of cells shifts in parallel for each insert or pop
//   busy rises only when the two-entry queue is full and the front holds an
//   item; the receiver cannot hold results off, so this never happens in use
//   reset empties the store and the queue and drops anything in flight
// ----------------------------------------------------------------------------
module complex_magnitude_priority_queue_unit
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    command,
    input  logic signed [cmpq_pkg::PART_WIDTH-1:0]  real_part,
    input  logic signed [cmpq_pkg::PART_WIDTH-1:0]  imag_part,
    output logic                                    done,
    output logic [1:0]                              status,
    output logic signed [cmpq_pkg::PART_WIDTH-1:0]  out_real,
    output logic signed [cmpq_pkg::PART_WIDTH-1:0]  out_imag,
    output logic [cmpq_pkg::COUNT_W-1:0]            entry_count,
    output logic                                    now_empty
);

    // front to queue
    logic               fifo_push;
    cmpq_pkg::op_item_t fifo_push_item;
    logic               fifo_full;

    // queue to sorted array
    logic               fifo_not_empty;
    logic               fifo_pop;
    cmpq_pkg::op_item_t fifo_head_item;

    // squaring stage, key sum on its way into the queue
    cmpq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .real_part (real_part),
        .imag_part (imag_part),
        .fifo_full (fifo_full),
        .busy      (busy),
        .push      (fifo_push),
        .push_item (fifo_push_item)
    );

    // decouples the front end from the cell array
    cmpq_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_item (fifo_push_item),
        .pop       (fifo_pop),
        .full      (fifo_full),
        .not_empty (fifo_not_empty),
        .head_item (fifo_head_item)
    );

    // sorted cells, count and registered result
    cmpq_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (fifo_not_empty),
        .head_item   (fifo_head_item),
        .head_pop    (fifo_pop),
        .done        (done),
        .status      (status),
        .out_real    (out_real),
        .out_imag    (out_imag),
        .entry_count (entry_count),
        .now_empty   (now_empty)
    );

    // a full reject only happens at capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == cmpq_pkg::ST_FULL))
        |-> (entry_count == cmpq_pkg::COUNT_W'(cmpq_pkg::CAPACITY)))
        else $error("full status below capacity");

    // an empty pop leaves nothing stored
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == cmpq_pkg::ST_EMPTY)) |-> (now_empty && (entry_count == '0)))
        else $error("empty status with entries stored");

    // only a pop returns data
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != cmpq_pkg::ST_POPPED)) |-> ((out_real == '0) && (out_imag == '0)))
        else $error("data returned without a pop");

    // the count never passes capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= cmpq_pkg::COUNT_W'(cmpq_pkg::CAPACITY))
        else $error("entry count above capacity");

endmodule

/* bench/cmpq_checker.sv */
// ----------------------------------------------------------------------------
// cmpq_checker
// watches the item and result channels of the priority queue, keeps its own
// sorted store, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module cmpq_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic                                   command,
    input  logic signed [cmpq_pkg::PART_WIDTH-1:0] real_part,
    input  logic signed [cmpq_pkg::PART_WIDTH-1:0] imag_part,
    input  logic                                   done,
    input  logic [1:0]                             status,
    input  logic signed [cmpq_pkg::PART_WIDTH-1:0] out_real,
    input  logic signed [cmpq_pkg::PART_WIDTH-1:0] out_imag,
    input  logic [cmpq_pkg::COUNT_W-1:0]           entry_count,
    input  logic                                   now_empty,
    output int                                     fail_count,
    output int                                     pending,
    output int                                     checked_count,
    output int                                     full_count,
    output int                                     empty_count,
    output int                                     max_depth
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        cmpq_pkg::status_t                      status;
        logic signed [cmpq_pkg::PART_WIDTH-1:0] re;
        logic signed [cmpq_pkg::PART_WIDTH-1:0] im;
        logic [cmpq_pkg::COUNT_W-1:0]           count;
        logic                                   empty;
    } queue_result_t;

    // sorted store, slot 0 holds the largest key
    logic signed [cmpq_pkg::PART_WIDTH-1:0] sorted_re [cmpq_pkg::CAPACITY];
    logic signed [cmpq_pkg::PART_WIDTH-1:0] sorted_im [cmpq_pkg::CAPACITY];
    logic [cmpq_pkg::KEY_W-1:0]             sorted_key[cmpq_pkg::CAPACITY];
    int                                     sorted_count;

    queue_result_t expected_results[$];
    int            errors;
    int            n_checked;
    int            n_full;
    int            n_empty;
    int            deepest;

    function automatic queue_result_t apply_queue_op(
        input logic cmd,
        input logic signed [cmpq_pkg::PART_WIDTH-1:0] re,
        input logic signed [cmpq_pkg::PART_WIDTH-1:0] im);
        queue_result_t              res;
        longint                     sr;
        longint                     si;
        logic [cmpq_pkg::KEY_W-1:0] key;
        int                         pos;
        res = '0;
        if (cmd == cmpq_pkg::CMD_INSERT)
        begin
            if (sorted_count >= cmpq_pkg::CAPACITY)
            begin
                res.status = cmpq_pkg::ST_FULL;
            end
            else
            begin
                sr  = re;
                si  = im;
                key = cmpq_pkg::KEY_W'(sr * sr + si * si);
                // new entry goes behind every entry with a key not smaller
                pos = 0;
                while (pos < sorted_count && sorted_key[pos] >= key)
                    pos++;
                for (int i = sorted_count; i > pos; i--)
                begin
                    sorted_re[i]  = sorted_re[i-1];
                    sorted_im[i]  = sorted_im[i-1];
                    sorted_key[i] = sorted_key[i-1];
                end
                sorted_re[pos]  = re;
                sorted_im[pos]  = im;
                sorted_key[pos] = key;
                sorted_count++;
                res.status = cmpq_pkg::ST_INSERTED;
            end
        end
        else
        begin
            if (sorted_count == 0)
            begin
                res.status = cmpq_pkg::ST_EMPTY;
            end
            else
            begin
                res.re = sorted_re[0];
                res.im = sorted_im[0];
                for (int i = 1; i < sorted_count; i++)
                begin
                    sorted_re[i-1]  = sorted_re[i];
                    sorted_im[i-1]  = sorted_im[i];
                    sorted_key[i-1] = sorted_key[i];
                end
                sorted_count--;
                res.status = cmpq_pkg::ST_POPPED;
            end
        end
        res.count = cmpq_pkg::COUNT_W'(sorted_count);
        res.empty = (sorted_count == 0);
        return res;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t mismatch %s expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        queue_result_t want;
        queue_result_t got_item;
        if (!rst_n)
        begin
            sorted_count = 0;
            expected_results.delete();
        end
        else
        begin
            // results first, they belong to items taken at earlier edges
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result status %0d real %0d imag %0d count %0d",
                             $time, status, out_real, out_imag, entry_count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    n_checked++;
                    check_field("status", int'(want.status), int'(status));
                    check_field("out_real", int'(want.re), int'(out_real));
                    check_field("out_imag", int'(want.im), int'(out_imag));
                    check_field("entry_count", int'(want.count), int'(entry_count));
                    check_field("now_empty", int'(want.empty), int'(now_empty));
                end
            end
            if (start && !busy)
            begin
                got_item = apply_queue_op(command, real_part, imag_part);
                if (got_item.status == cmpq_pkg::ST_FULL)
                    n_full++;
                if (got_item.status == cmpq_pkg::ST_EMPTY)
                    n_empty++;
                if (sorted_count > deepest)
                    deepest = sorted_count;
                expected_results.push_back(got_item);
            end
        end
        fail_count    <= errors;
        pending       <= expected_results.size();
        checked_count <= n_checked;
        full_count    <= n_full;
        empty_count   <= n_empty;
        max_depth     <= deepest;
    end

endmodule

/* bench/tb_complex_magnitude_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// tb_complex_magnitude_priority_queue_unit
// drives insert and pop items into the complex magnitude priority queue and
// gives the verdict; a checker beside the block predicts and compares results
// ----------------------------------------------------------------------------
module tb_complex_magnitude_priority_queue_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 316;

    logic                                   clk = 1'b0;
    logic                                   rst_n;
    logic                                   start;
    logic                                   busy;
    logic                                   command;
    logic signed [cmpq_pkg::PART_WIDTH-1:0] real_part;
    logic signed [cmpq_pkg::PART_WIDTH-1:0] imag_part;
    logic                                   done;
    logic [1:0]                             status;
    logic signed [cmpq_pkg::PART_WIDTH-1:0] out_real;
    logic signed [cmpq_pkg::PART_WIDTH-1:0] out_imag;
    logic [cmpq_pkg::COUNT_W-1:0]           entry_count;
    logic                                   now_empty;

    int fail_count;
    int pending;
    int checked_count;
    int full_count;
    int empty_count;
    int max_depth;

    // chance in percent that the sender leaves a cycle empty before an item
    int sender_idle_pct;

    complex_magnitude_priority_queue_unit i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .real_part   (real_part),
        .imag_part   (imag_part),
        .done        (done),
        .status      (status),
        .out_real    (out_real),
        .out_imag    (out_imag),
        .entry_count (entry_count),
        .now_empty   (now_empty)
    );

    cmpq_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .real_part     (real_part),
        .imag_part     (imag_part),
        .done          (done),
        .status        (status),
        .out_real      (out_real),
        .out_imag      (out_imag),
        .entry_count   (entry_count),
        .now_empty     (now_empty),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .full_count    (full_count),
        .empty_count   (empty_count),
        .max_depth     (max_depth)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one item: random idle cycles first, then hold start until taken
    // start stays high across back-to-back items, no lower-and-raise
    task automatic send_item(input logic cmd,
                             input logic signed [cmpq_pkg::PART_WIDTH-1:0] re,
                             input logic signed [cmpq_pkg::PART_WIDTH-1:0] im);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        command   <= cmd;
        real_part <= re;
        imag_part <= im;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // a part value: small ones give many equal keys, extremes hit the key range
    function automatic logic signed [cmpq_pkg::PART_WIDTH-1:0] pick_part();
        int v;
        case ($urandom_range(3))
            0:
            begin
                v = int'($urandom_range(8)) - 4;
            end
            1:
            begin
                case ($urandom_range(5))
                    0:       v = -32768;
                    1:       v = -32767;
                    2:       v = -1;
                    3:       v = 0;
                    4:       v = 1;
                    default: v = 32767;
                endcase
            end
            default:
            begin
                v = int'($urandom);
            end
        endcase
        return v[cmpq_pkg::PART_WIDTH-1:0];
    endfunction

    // one phase of random items in segments: filling runs that reach the
    // full store, draining runs that reach the empty store, and balanced noise
    task automatic random_phase(input int n_items);
        int insert_pct;
        int seg_left;
        int mode;
        logic cmd;
        insert_pct = 92;
        seg_left   = $urandom_range(100, 140);
        for (int n = 0; n < n_items; n++)
        begin
            if (seg_left == 0)
            begin
                mode = $urandom_range(2);
                case (mode)
                    0:
                    begin
                        insert_pct = 92;
                        seg_left   = $urandom_range(100, 140);
                    end
                    1:
                    begin
                        insert_pct = 15;
                        seg_left   = $urandom_range(40, 120);
                    end
                    default:
                    begin
                        insert_pct = 50;
                        seg_left   = $urandom_range(40, 120);
                    end
                endcase
            end
            seg_left--;
            cmd = ($urandom_range(99) < insert_pct) ? cmpq_pkg::CMD_INSERT : cmpq_pkg::CMD_POP;
            // pop items still carry random part fields, the block ignores them
            send_item(cmd, pick_part(), pick_part());
        end
    endtask

    initial
    begin
        start           <= 1'b0;
        command         <= cmpq_pkg::CMD_INSERT;
        real_part       <= '0;
        imag_part       <= '0;
        rst_n           <= 1'b0;
        sender_idle_pct = 24;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pop on empty store
        send_item(cmpq_pkg::CMD_POP, pick_part(), pick_part());
        // largest possible key, both parts at the negative extreme
        send_item(cmpq_pkg::CMD_INSERT, -16'sd32768, -16'sd32768);
        send_item(cmpq_pkg::CMD_INSERT, 16'sd32767, 16'sd32767);
        send_item(cmpq_pkg::CMD_INSERT, 16'sd0, 16'sd0);
        // equal keys, must leave in arrival order
        send_item(cmpq_pkg::CMD_INSERT, 16'sd3, 16'sd4);
        send_item(cmpq_pkg::CMD_INSERT, 16'sd4, -16'sd3);
        send_item(cmpq_pkg::CMD_INSERT, -16'sd5, 16'sd0);
        send_item(cmpq_pkg::CMD_INSERT, 16'sd0, -16'sd5);
        send_item(cmpq_pkg::CMD_INSERT, -16'sd32768, 16'sd0);
        send_item(cmpq_pkg::CMD_INSERT, 16'sd0, -16'sd32768);
        send_item(cmpq_pkg::CMD_INSERT, 16'sd32767, -16'sd32768);
        // drain all ten and one more pop on the empty store
        repeat (11)
            send_item(cmpq_pkg::CMD_POP, pick_part(), pick_part());

        // random part in three idle settings: light, heavy, none
        random_phase(ITEMS_PER_PHASE);
        sender_idle_pct = 63;
        random_phase(ITEMS_PER_PHASE);
        sender_idle_pct = 0;
        random_phase(ITEMS_PER_PHASE);

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // room for any stray result after the last one
        repeat (10)
            @(posedge clk);

        $display("checked %0d results, %0d inserts into a full store, %0d pops on empty",
                 checked_count, full_count, empty_count);
        $display("deepest store reached %0d of %0d entries", max_depth, cmpq_pkg::CAPACITY);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
